// ===== sv/edlc_pkg.sv =====
// Shared types, codes and decoder tables for the encoder dimmer level control.
package edlc_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int LEVEL_W   = 7;
    localparam int TICK_W    = 32;
    localparam int EVENT_W   = 3;
    localparam int QUAD_W    = 3;

    typedef logic [LEVEL_W-1:0] t_level;
    typedef logic [TICK_W-1:0]  t_tick;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_LEVELS   = 3'd0,
        CFG_REV_LOCK     = 3'd1,
        CFG_ACCEL_WINDOW = 3'd2,
        CFG_ACCEL_STEP   = 3'd3,
        CFG_SNAP_WINDOW  = 3'd4,
        CFG_DEBOUNCE     = 3'd5,
        CFG_MODE         = 3'd6
    } t_cfg_idx;

    // Mode bit positions
    localparam int MODE_REVERSE = 0;
    localparam int MODE_HALF    = 1;
    localparam int MODE_ACCEL   = 2;
    localparam int MODE_WAKE    = 3;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DN   = 2'd2
    } t_dir;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE      = 3'd0,
        EV_STEP_UP   = 3'd1,
        EV_STEP_DN   = 3'd2,
        EV_SNAP_FULL = 3'd3,
        EV_SNAP_OFF  = 3'd4,
        EV_REJECT    = 3'd5
    } t_turn_event;

    typedef logic [5:0] t_entry;

    localparam t_entry FLAG_UP   = 6'h10;
    localparam t_entry FLAG_DN   = 6'h20;
    localparam t_entry NEXT_MASK = 6'h0f;

    // Rows by decoder state, columns by {A,B}
    localparam t_entry TBL_FULL [8][4] = '{
        '{6'd0, 6'd2, 6'd4, 6'd0},
        '{6'd3, 6'd0, 6'd1, 6'd0 | FLAG_UP},
        '{6'd3, 6'd2, 6'd0, 6'd0},
        '{6'd3, 6'd2, 6'd1, 6'd0},
        '{6'd6, 6'd0, 6'd4, 6'd0},
        '{6'd6, 6'd5, 6'd0, 6'd0 | FLAG_DN},
        '{6'd6, 6'd5, 6'd4, 6'd0},
        '{6'd0, 6'd0, 6'd0, 6'd0}
    };

    localparam t_entry TBL_HALF [8][4] = '{
        '{6'd3,           6'd2, 6'd1, 6'd0},
        '{6'd3 | FLAG_DN, 6'd0, 6'd1, 6'd0},
        '{6'd3 | FLAG_UP, 6'd2, 6'd0, 6'd0},
        '{6'd3,           6'd5, 6'd4, 6'd0},
        '{6'd3,           6'd3, 6'd4, 6'd0 | FLAG_UP},
        '{6'd3,           6'd5, 6'd3, 6'd0 | FLAG_DN},
        '{6'd0,           6'd0, 6'd0, 6'd0},
        '{6'd0,           6'd0, 6'd0, 6'd0}
    };

endpackage

// ===== sv/encoder_dimmer_level_control_core.sv =====
// Top level: quadrature encoder dimmer with reversal reject, acceleration, snap and button toggle.

// One pin sample is accepted per cycle while o_in_ready is high:
// the sample is captured in an input register, decoded, filtered and applied to the
// dimmer state by one pass of logic, and the result is held in an output register.
// A new request is taken every cycle as long as the result side keeps up; a stalled
// result holds the pass, and blocks new samples only once the input register is full.
// Configuration writes are accepted every cycle and take effect on the next sample
// processed. The last SNAP_COUNT click times are kept in a small register file; slots
// are read only after being written since the last snap or direction change.
module encoder_dimmer_level_control_core #(
    parameter int SNAP_COUNT = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [edlc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [edlc_pkg::CFG_DAT_W-1:0] i_cfg_data,
    // sample channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_phase_a,
    input  logic                        i_phase_b,
    input  logic                        i_button_level,
    input  logic [edlc_pkg::TICK_W-1:0] i_now_tick,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [edlc_pkg::LEVEL_W-1:0] o_level,
    output logic                        o_lamp_on,
    output logic [edlc_pkg::EVENT_W-1:0] o_turn_event,
    output logic                        o_button_toggled
);
    import edlc_pkg::*;

    localparam int IDX_W = $clog2(SNAP_COUNT);
    localparam int CNT_W = $clog2(SNAP_COUNT + 1);

    // configuration
    t_level     r_num_levels;
    t_tick      r_rev_lock;
    t_tick      r_accel_win;
    t_level     r_accel_step;
    t_tick      r_snap_win;
    t_tick      r_debounce;
    logic [3:0] r_mode;

    // input register
    logic       r_in_valid;
    logic       r_a, r_b, r_btn;
    t_tick      r_now;

    // dimmer state
    logic [QUAD_W-1:0] r_quad;
    t_dir              r_last_dir;
    t_tick             r_last_time;
    t_tick             r_snap_times [SNAP_COUNT];
    logic [IDX_W-1:0]  r_snap_idx;
    logic [CNT_W-1:0]  r_snap_cnt;
    t_dir              r_snap_dir;
    t_level            r_dim_level;
    logic              r_on;
    logic              r_btn_stable;
    logic              r_btn_cand;
    t_tick             r_btn_time;

    // result register
    logic        r_out_valid;
    t_turn_event r_event;
    logic        r_toggled;

    // next values
    logic [QUAD_W-1:0] n_quad;
    t_dir              n_last_dir;
    t_tick             n_last_time;
    logic              n_snap_wr;
    logic [IDX_W-1:0]  n_snap_wr_idx;
    logic [IDX_W-1:0]  n_snap_idx;
    logic [CNT_W-1:0]  n_snap_cnt;
    t_dir              n_snap_dir;
    t_level            n_dim_level;
    logic              n_on;
    logic              n_btn_stable;
    logic              n_btn_cand;
    t_tick             n_btn_time;
    t_turn_event       n_event;
    logic              n_toggled;

    // decode intermediates
    logic              stage_go;
    t_entry            entry;
    t_dir              dir;
    t_dir              opp;
    t_tick             since;
    t_level            step;
    logic [IDX_W-1:0]  idx_base;
    logic [IDX_W-1:0]  oldest;
    logic [CNT_W-1:0]  cnt_base;
    logic [CNT_W-1:0]  cnt_new;
    logic              snap;
    logic [LEVEL_W:0]  sum;

    assign stage_go    = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || stage_go;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid      = r_out_valid;
    assign o_level          = r_dim_level;
    assign o_lamp_on        = r_on;
    assign o_turn_event     = r_event;
    assign o_button_toggled = r_toggled;

    always_comb begin
        entry = r_mode[MODE_HALF] ? TBL_HALF[r_quad][{r_a, r_b}]
                                  : TBL_FULL[r_quad][{r_a, r_b}];
        n_quad = QUAD_W'(entry & NEXT_MASK);

        dir = DIR_NONE;
        if ((entry & FLAG_UP) != '0) begin
            dir = DIR_UP;
        end else if ((entry & FLAG_DN) != '0) begin
            dir = DIR_DN;
        end
        if (r_mode[MODE_REVERSE] && dir != DIR_NONE) begin
            dir = (dir == DIR_UP) ? DIR_DN : DIR_UP;
        end
        opp   = (dir == DIR_UP) ? DIR_DN : DIR_UP;
        since = r_now - r_last_time;

        step = (r_mode[MODE_ACCEL] && dir == r_last_dir && since < r_accel_win)
               ? r_accel_step : LEVEL_W'(1);

        // snap history: restart on a direction change
        idx_base = (dir != r_snap_dir) ? '0 : r_snap_idx;
        cnt_base = (dir != r_snap_dir) ? '0 : r_snap_cnt;
        oldest   = (idx_base == IDX_W'(SNAP_COUNT - 1)) ? '0 : idx_base + IDX_W'(1);
        cnt_new  = (cnt_base == CNT_W'(SNAP_COUNT)) ? cnt_base : cnt_base + CNT_W'(1);
        snap     = (cnt_new >= CNT_W'(SNAP_COUNT))
                   && ((r_now - r_snap_times[oldest]) <= r_snap_win);
        sum      = {1'b0, r_dim_level} + {1'b0, step};

        n_last_dir    = r_last_dir;
        n_last_time   = r_last_time;
        n_snap_wr     = 1'b0;
        n_snap_wr_idx = idx_base;
        n_snap_idx    = r_snap_idx;
        n_snap_cnt    = r_snap_cnt;
        n_snap_dir    = r_snap_dir;
        n_dim_level   = r_dim_level;
        n_on          = r_on;
        n_event       = EV_NONE;

        if (dir != DIR_NONE) begin
            if (r_last_dir == opp && since < r_rev_lock) begin
                n_event = EV_REJECT;
            end else begin
                n_last_dir  = dir;
                n_last_time = r_now;
                n_snap_dir  = dir;
                n_snap_wr   = 1'b1;
                if (snap) begin
                    n_snap_cnt = '0;
                    n_snap_idx = '0;
                    if (dir == DIR_UP) begin
                        n_dim_level = r_num_levels;
                        n_on        = 1'b1;
                        n_event     = EV_SNAP_FULL;
                    end else begin
                        n_dim_level = '0;
                        n_event     = EV_SNAP_OFF;
                    end
                end else begin
                    n_snap_cnt = cnt_new;
                    n_snap_idx = oldest;
                    if (dir == DIR_UP) begin
                        n_dim_level = (sum > {1'b0, r_num_levels}) ? r_num_levels
                                                                   : sum[LEVEL_W-1:0];
                        n_event     = EV_STEP_UP;
                    end else begin
                        n_dim_level = (r_dim_level > step) ? r_dim_level - step : '0;
                        n_event     = EV_STEP_DN;
                    end
                end
                if (r_mode[MODE_WAKE] && n_dim_level != '0) begin
                    n_on = 1'b1;
                end
            end
        end

        // button debounce runs after the turn, on the updated lamp state
        n_btn_cand   = r_btn_cand;
        n_btn_time   = r_btn_time;
        n_btn_stable = r_btn_stable;
        n_toggled    = 1'b0;
        if (r_btn != r_btn_cand) begin
            n_btn_cand = r_btn;
            n_btn_time = r_now;
        end else if (r_btn_cand != r_btn_stable && (r_now - r_btn_time) >= r_debounce) begin
            n_btn_stable = r_btn_cand;
            if (!r_btn_cand) begin
                n_on      = ~n_on;
                n_toggled = 1'b1;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_levels <= LEVEL_W'(100);
            r_rev_lock   <= TICK_W'(240000);
            r_accel_win  <= TICK_W'(1440000);
            r_accel_step <= LEVEL_W'(4);
            r_snap_win   <= TICK_W'(9600000);
            r_debounce   <= TICK_W'(1440000);
            r_mode       <= 4'd12;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NUM_LEVELS:   r_num_levels <= i_cfg_data[LEVEL_W-1:0];
                CFG_REV_LOCK:     r_rev_lock   <= i_cfg_data[TICK_W-1:0];
                CFG_ACCEL_WINDOW: r_accel_win  <= i_cfg_data[TICK_W-1:0];
                CFG_ACCEL_STEP:   r_accel_step <= i_cfg_data[LEVEL_W-1:0];
                CFG_SNAP_WINDOW:  r_snap_win   <= i_cfg_data[TICK_W-1:0];
                CFG_DEBOUNCE:     r_debounce   <= i_cfg_data[TICK_W-1:0];
                CFG_MODE:         r_mode       <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // input register and handshake control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (stage_go) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_a   <= i_phase_a;
            r_b   <= i_phase_b;
            r_btn <= i_button_level;
            r_now <= i_now_tick;
        end
        if (stage_go && r_in_valid) begin
            r_event   <= n_event;
            r_toggled <= n_toggled;
        end
    end

    // click history slots, no reset
    always_ff @(posedge i_clk) begin
        if (stage_go && r_in_valid && n_snap_wr) begin
            r_snap_times[n_snap_wr_idx] <= r_now;
        end
    end

    // dimmer state, advance once per processed sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quad       <= '0;
            r_last_dir   <= DIR_NONE;
            r_last_time  <= '0;
            r_snap_idx   <= '0;
            r_snap_cnt   <= '0;
            r_snap_dir   <= DIR_NONE;
            r_dim_level  <= '0;
            r_on         <= 1'b1;
            r_btn_stable <= 1'b1;
            r_btn_cand   <= 1'b1;
            r_btn_time   <= '0;
        end else if (stage_go && r_in_valid) begin
            r_quad       <= n_quad;
            r_last_dir   <= n_last_dir;
            r_last_time  <= n_last_time;
            r_snap_idx   <= n_snap_idx;
            r_snap_cnt   <= n_snap_cnt;
            r_snap_dir   <= n_snap_dir;
            r_dim_level  <= n_dim_level;
            r_on         <= n_on;
            r_btn_stable <= n_btn_stable;
            r_btn_cand   <= n_btn_cand;
            r_btn_time   <= n_btn_time;
        end
    end

    a_snap_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_snap_cnt <= CNT_W'(SNAP_COUNT))
        else $error("snap count above depth");

    a_snap_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_turn_event == EV_SNAP_FULL || o_turn_event == EV_SNAP_OFF))
        |-> (r_snap_cnt == '0 && r_snap_idx == '0))
        else $error("snap did not restart click history");

    a_snap_off_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_turn_event == EV_SNAP_OFF) |-> (o_level == '0))
        else $error("snap off left nonzero level");

    a_toggle_on_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_button_toggled) |-> (!r_btn_stable && !r_btn_cand))
        else $error("toggle without a debounced press");

endmodule
